@@ design/desc_pkg.sv @@
// ----------------------------------------------------------------------------
// desc_pkg
// shared types, codes and helpers for the dual encoder setting control
// ----------------------------------------------------------------------------
`default_nettype none

package desc_pkg;

  // direction codes of the lagging-edge decoder
  typedef logic [1:0] dir_t;
  localparam dir_t DIR_IDLE = 2'd0;
  localparam dir_t DIR_UP   = 2'd1;
  localparam dir_t DIR_DOWN = 2'd2;

  // configuration register indexes
  localparam logic CFG_MIN = 1'b0;
  localparam logic CFG_MAX = 1'b1;

  // digit scan phases
  typedef logic [1:0] phase_t;
  localparam phase_t PH_DIV_TENS   = 2'd0;
  localparam phase_t PH_DIV_UNITS  = 2'd1;
  localparam phase_t PH_BEAT_TENS  = 2'd2;
  localparam phase_t PH_BEAT_UNITS = 2'd3;

  typedef logic [6:0] count_t;
  typedef logic [3:0] digit_t;

  // reset values
  localparam count_t MIN_RST  = 7'd2;
  localparam count_t MAX_RST  = 7'd32;
  localparam count_t BEAT_RST = 7'd4;
  localparam count_t DIV_RST  = 7'd7;

  // reciprocal of ten: (v * 205) >> 11 is exact for every 7-bit v
  localparam int unsigned RECIP_TEN  = 205;
  localparam int unsigned RECIP_SHFT = 11;

  // decoder state of one encoder
  typedef struct packed {
    logic last_a;
    logic last_b;
    dir_t dir;
  } enc_state_t;

  // decoder outcome for one scan
  typedef struct packed {
    enc_state_t nxt;
    logic       up;
    logic       down;
  } enc_res_t;

  // one scan of the lagging-edge decoder
  function automatic enc_res_t enc_update(enc_state_t s, logic a, logic b);
    enc_res_t r;
    r.nxt.last_a = a;
    r.nxt.last_b = b;
    r.nxt.dir    = s.dir;
    r.up         = 1'b0;
    r.down       = 1'b0;
    // line A edge wins when both lines fall together
    if (!a && s.last_a) begin
      if (s.dir == DIR_IDLE) begin
        r.nxt.dir = DIR_DOWN;
      end else if (s.dir == DIR_UP) begin
        r.nxt.dir = DIR_IDLE;
        r.up      = 1'b1;
      end
    end else if (!b && s.last_b) begin
      if (s.dir == DIR_IDLE) begin
        r.nxt.dir = DIR_UP;
      end else if (s.dir == DIR_DOWN) begin
        r.nxt.dir = DIR_IDLE;
        r.down    = 1'b1;
      end
    end
    return r;
  endfunction

  // count step with wrap: below min goes to max, then above max goes to min
  function automatic count_t count_move(count_t v, logic up, logic down,
                                        count_t min_v, count_t max_v);
    logic [7:0] n;
    logic [7:0] n1;
    logic [7:0] n2;
    logic       neg;
    n   = up ? ({1'b0, v} + 8'd1) : ({1'b0, v} - 8'd1);
    // value went to minus one
    neg = down && (v == 7'd0);
    n1  = (neg || (n < {1'b0, min_v})) ? {1'b0, max_v} : n;
    n2  = (n1 > {1'b0, max_v}) ? {1'b0, min_v} : n1;
    return (up || down) ? n2[6:0] : v;
  endfunction

  // tens or units digit of a 7-bit count
  function automatic digit_t digit_of(count_t v, logic units);
    logic [14:0] prod;
    logic [3:0]  q;
    logic [6:0]  q10;
    logic [6:0]  rem;
    prod = {8'd0, v} * 15'(RECIP_TEN);
    q    = prod[14:RECIP_SHFT];
    q10  = {q, 3'd0} - {3'd0, q} - {3'd0, q} + {2'd0, q, 1'b0} + {2'd0, q, 1'b0};
    rem  = v - q10;
    return units ? rem[3:0] : q;
  endfunction

endpackage

`default_nettype wire

@@ design/dual_encoder_setting_control_unit.sv @@
// ----------------------------------------------------------------------------
// dual_encoder_setting_control_unit
// two quadrature encoder decoders with wrapping counts, switch latches and
// a four-phase decimal digit scan, one panel scan per request
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  in_     | input     | in_valid / in_stall  | encoder lines, switch levels
//  out_    | output    | out_valid / out_stall| counts, digit, latches
//  cfg_    | input     | cfg_we               | cfg_index, cfg_data
//
//  one request per cycle while in_stall is low; its result shows in the cycle after acceptance
//  all decoding is combinational logic between the input and the result register
//  in_stall is high only while a result is held by out_stall
//  rst_n is synchronous and restores the documented state and register values
// ----------------------------------------------------------------------------
`default_nettype none

module dual_encoder_setting_control_unit (
  input  wire                    clk,
  input  wire                    rst_n,
  // configuration
  input  wire                    cfg_we,
  input  wire                    cfg_index,
  input  wire desc_pkg::count_t  cfg_data,
  // scan request
  input  wire                    in_valid,
  output logic                   in_stall,
  input  wire                    in_beat_enc_a,
  input  wire                    in_beat_enc_b,
  input  wire                    in_div_enc_a,
  input  wire                    in_div_enc_b,
  input  wire                    in_beat_button,
  input  wire                    in_div_button,
  // result
  output logic                   out_valid,
  input  wire                    out_stall,
  output desc_pkg::count_t       out_beats_count,
  output desc_pkg::count_t       out_divisions_count,
  output desc_pkg::phase_t       out_digit_position,
  output desc_pkg::digit_t       out_digit_value,
  output logic                   out_beat_toggle,
  output logic                   out_div_toggle
);
  import desc_pkg::*;

  count_t     min_r, max_r;
  enc_state_t beat_enc_r, div_enc_r;
  count_t     beats_r, divs_r;
  phase_t     phase_r;
  logic       beat_btn_r, div_btn_r;
  logic       beat_lat_r, div_lat_r;
  logic       out_valid_r;

  enc_res_t   beat_res, div_res;
  count_t     beats_nxt, divs_nxt;
  logic       beat_lat_nxt, div_lat_nxt;
  count_t     digit_src;
  digit_t     digit_nxt;
  logic       in_accept;

  // handshake
  assign in_stall  = out_valid_r && out_stall;
  assign in_accept = in_valid && !in_stall;
  assign out_valid = out_valid_r;

  // decode, count and digit select for the current scan
  always_comb begin
    beat_res     = enc_update(beat_enc_r, in_beat_enc_a, in_beat_enc_b);
    div_res      = enc_update(div_enc_r, in_div_enc_a, in_div_enc_b);
    beats_nxt    = count_move(beats_r, beat_res.up, beat_res.down, min_r, max_r);
    divs_nxt     = count_move(divs_r, div_res.up, div_res.down, min_r, max_r);
    beat_lat_nxt = beat_lat_r ^ (in_beat_button && !beat_btn_r);
    div_lat_nxt  = div_lat_r ^ (in_div_button && !div_btn_r);
    unique case (phase_r)
      PH_DIV_TENS, PH_DIV_UNITS: digit_src = divs_nxt;
      default:                   digit_src = beats_nxt;
    endcase
    digit_nxt = digit_of(digit_src, phase_r[0]);
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r <= MIN_RST;
      max_r <= MAX_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MIN: min_r <= cfg_data;
        CFG_MAX: max_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // scan state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beat_enc_r <= '{last_a: 1'b1, last_b: 1'b1, dir: DIR_IDLE};
      div_enc_r  <= '{last_a: 1'b1, last_b: 1'b1, dir: DIR_IDLE};
      beats_r    <= BEAT_RST;
      divs_r     <= DIV_RST;
      phase_r    <= PH_DIV_TENS;
      beat_btn_r <= 1'b0;
      div_btn_r  <= 1'b0;
      beat_lat_r <= 1'b0;
      div_lat_r  <= 1'b0;
    end else if (in_accept) begin
      beat_enc_r <= beat_res.nxt;
      div_enc_r  <= div_res.nxt;
      beats_r    <= beats_nxt;
      divs_r     <= divs_nxt;
      phase_r    <= phase_r + 2'd1;
      beat_btn_r <= in_beat_button;
      div_btn_r  <= in_div_button;
      beat_lat_r <= beat_lat_nxt;
      div_lat_r  <= div_lat_nxt;
    end
  end

  // result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_accept) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_beats_count     <= beats_nxt;
      out_divisions_count <= divs_nxt;
      out_digit_position  <= phase_r;
      out_digit_value     <= digit_nxt;
      out_beat_toggle     <= beat_lat_nxt;
      out_div_toggle      <= div_lat_nxt;
    end
  end

  // checks
  a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> out_valid_r)
    else $error("accepted request produced no result");

  a_phase_advances: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> (phase_r == $past(phase_r) + 2'd1) &&
                  (out_digit_position == $past(phase_r)))
    else $error("digit scan phase out of step");

  a_units_below_ten: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_digit_position[0]) |-> (out_digit_value <= 4'd9))
    else $error("units digit above nine");

  a_dir_legal: assert property (@(posedge clk) disable iff (!rst_n)
    (beat_enc_r.dir != 2'd3) && (div_enc_r.dir != 2'd3))
    else $error("decoder direction took an unused code");

endmodule

`default_nettype wire

@@ bench/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// drives panel scan requests into the dual encoder setting control, changes
// the count limits between phases, and checks every readout against an
// in-bench model of the decoders, counts, latches and digit scan
// ----------------------------------------------------------------------------

module testbench;
  import desc_pkg::*;

  localparam int PHASES          = 9;
  localparam int SCANS_PER_PHASE = 65;
  localparam int IDLE_PCT        = 19;
  localparam int QUIET_FROM      = 150;
  localparam int QUIET_TO        = 280;
  localparam int HOLD_AT         = 400;
  localparam int HOLD_CYCLES     = 50;
  localparam int MAX_REPORTS     = 20;
  localparam int LIMIT_NS        = 200000;

  // one panel scan: encoder line levels and switch levels
  typedef struct packed {
    logic beat_a;
    logic beat_b;
    logic div_a;
    logic div_b;
    logic beat_sw;
    logic div_sw;
  } scan_t;

  // one readout of the panel
  typedef struct packed {
    count_t beats;
    count_t divs;
    phase_t pos;
    digit_t digit;
    logic   beat_tog;
    logic   div_tog;
  } readout_t;

  // lagging-edge decoder state of one encoder
  typedef struct {
    logic last_a;
    logic last_b;
    dir_t dir;
  } decoder_t;

  // model of the panel logic plus the queue of readouts still to come
  class scan_scoreboard;
    count_t   lo_limit;
    count_t   hi_limit;
    decoder_t dec [2];
    count_t   beats;
    count_t   divs;
    phase_t   phase;
    logic     beat_sw_prev;
    logic     div_sw_prev;
    logic     beat_tog;
    logic     div_tog;
    readout_t expected_readouts [$];
    int       errors;

    function new();
      lo_limit = MIN_RST;
      hi_limit = MAX_RST;
      foreach (dec[i]) begin
        dec[i].last_a = 1'b1;
        dec[i].last_b = 1'b1;
        dec[i].dir    = DIR_IDLE;
      end
      beats        = BEAT_RST;
      divs         = DIV_RST;
      phase        = PH_DIV_TENS;
      beat_sw_prev = 1'b0;
      div_sw_prev  = 1'b0;
      beat_tog     = 1'b0;
      div_tog      = 1'b0;
      errors       = 0;
    endfunction

    function void write_reg(logic idx, count_t val);
      if (idx == CFG_MIN) begin
        lo_limit = val;
      end else begin
        hi_limit = val;
      end
    endfunction

    // +1, -1 or 0 for this scan; line A falling takes priority
    function int decode(bit which, logic a, logic b);
      int step;
      step = 0;
      if (!a && dec[which].last_a) begin
        if (dec[which].dir == DIR_IDLE) begin
          dec[which].dir = DIR_DOWN;
        end else if (dec[which].dir == DIR_UP) begin
          dec[which].dir = DIR_IDLE;
          step = 1;
        end
      end else if (!b && dec[which].last_b) begin
        if (dec[which].dir == DIR_IDLE) begin
          dec[which].dir = DIR_UP;
        end else if (dec[which].dir == DIR_DOWN) begin
          dec[which].dir = DIR_IDLE;
          step = -1;
        end
      end
      dec[which].last_a = a;
      dec[which].last_b = b;
      return step;
    endfunction

    // below min goes to max first, then above max goes to min
    function count_t move_count(count_t v, int step);
      int n;
      if (step == 0) return v;
      n = int'(v) + step;
      if (n < int'(lo_limit)) n = int'(hi_limit);
      if (n > int'(hi_limit)) n = int'(lo_limit);
      return count_t'(n[6:0]);
    endfunction

    function void note_scan(scan_t s);
      readout_t want;
      // rising switch edges flip the latches
      if (s.beat_sw && !beat_sw_prev) beat_tog = ~beat_tog;
      beat_sw_prev = s.beat_sw;
      if (s.div_sw && !div_sw_prev) div_tog = ~div_tog;
      div_sw_prev = s.div_sw;
      beats = move_count(beats, decode(1'b0, s.beat_a, s.beat_b));
      divs  = move_count(divs, decode(1'b1, s.div_a, s.div_b));
      want.beats = beats;
      want.divs  = divs;
      want.pos   = phase;
      case (phase)
        PH_DIV_TENS:   want.digit = digit_t'(divs / 10);
        PH_DIV_UNITS:  want.digit = digit_t'(divs % 10);
        PH_BEAT_TENS:  want.digit = digit_t'(beats / 10);
        default:       want.digit = digit_t'(beats % 10);
      endcase
      want.beat_tog = beat_tog;
      want.div_tog  = div_tog;
      expected_readouts.push_back(want);
      phase = phase + 2'd1;
    endfunction

    function void check_field(string field, logic [6:0] want, logic [6:0] got);
      if (want !== got) begin
        if (errors < MAX_REPORTS)
          $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
        errors++;
      end
    endfunction

    function void check_readout(readout_t got);
      readout_t want;
      if (expected_readouts.size() == 0) begin
        if (errors < MAX_REPORTS)
          $display("%0t: readout with no request pending: beats %0d div %0d",
                   $time, got.beats, got.divs);
        errors++;
        return;
      end
      want = expected_readouts.pop_front();
      check_field("beats_count", want.beats, got.beats);
      check_field("divisions_count", want.divs, got.divs);
      check_field("digit_position", 7'(want.pos), 7'(got.pos));
      check_field("digit_value", 7'(want.digit), 7'(got.digit));
      check_field("beat_toggle", 7'(want.beat_tog), 7'(got.beat_tog));
      check_field("div_toggle", 7'(want.div_tog), 7'(got.div_tog));
    endfunction

    function int pending();
      return expected_readouts.size();
    endfunction
  endclass

  logic   clk            = 1'b0;
  logic   rst_n          = 1'b0;
  logic   cfg_we         = 1'b0;
  logic   cfg_index      = 1'b0;
  count_t cfg_data       = '0;
  logic   in_valid       = 1'b0;
  logic   in_stall;
  logic   in_beat_enc_a  = 1'b1;
  logic   in_beat_enc_b  = 1'b1;
  logic   in_div_enc_a   = 1'b1;
  logic   in_div_enc_b   = 1'b1;
  logic   in_beat_button = 1'b0;
  logic   in_div_button  = 1'b0;
  logic   out_valid;
  logic   out_stall      = 1'b0;
  count_t out_beats_count;
  count_t out_divisions_count;
  phase_t out_digit_position;
  digit_t out_digit_value;
  logic   out_beat_toggle;
  logic   out_div_toggle;

  scan_scoreboard sb;
  int sent_count = 0;
  int rx_count   = 0;

  dual_encoder_setting_control_unit uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_beat_enc_a       (in_beat_enc_a),
    .in_beat_enc_b       (in_beat_enc_b),
    .in_div_enc_a        (in_div_enc_a),
    .in_div_enc_b        (in_div_enc_b),
    .in_beat_button      (in_beat_button),
    .in_div_button       (in_div_button),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_beats_count     (out_beats_count),
    .out_divisions_count (out_divisions_count),
    .out_digit_position  (out_digit_position),
    .out_digit_value     (out_digit_value),
    .out_beat_toggle     (out_beat_toggle),
    .out_div_toggle      (out_div_toggle)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // overall time limit
  initial begin
    #(LIMIT_NS);
    $display("FAILED: results differ");
    $finish;
  end

  // offer one scan request, with random idle cycles ahead of it
  task automatic send_scan(input scan_t s);
    while (!(sent_count >= QUIET_FROM && sent_count < QUIET_TO) &&
           $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    {in_beat_enc_a, in_beat_enc_b, in_div_enc_a, in_div_enc_b,
     in_beat_button, in_div_button} <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_scan(s);
    sent_count++;
  endtask

  // stop offering and wait for every readout
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // write both count limits back to back
  task automatic set_limits(input count_t lo, input count_t hi);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_MIN;
    cfg_data  <= lo;
    @(posedge clk);
    cfg_index <= CFG_MAX;
    cfg_data  <= hi;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.write_reg(CFG_MIN, lo);
    sb.write_reg(CFG_MAX, hi);
  endtask

  // next A/B levels: mostly a turn in the bias direction, some bounce and noise
  function automatic logic [1:0] next_lines(logic [1:0] ab, int bias);
    int pos;
    int r;
    logic [1:0] ring [4];
    ring = '{2'b11, 2'b01, 2'b00, 2'b10};
    case (ab)
      2'b11:   pos = 0;
      2'b01:   pos = 1;
      2'b00:   pos = 2;
      default: pos = 3;
    endcase
    r = $urandom_range(99);
    if (r < 55) begin
      pos = pos + bias;
    end else if (r < 65) begin
      pos = pos - bias;
    end else if (r < 90) begin
      return ab;
    end else begin
      return 2'($urandom_range(3));
    end
    return ring[2'(pos + 4)];
  endfunction

  // readout monitor
  always @(posedge clk) begin : readout_monitor
    readout_t seen;
    if (rst_n && out_valid && !out_stall) begin
      seen.beats    = out_beats_count;
      seen.divs     = out_divisions_count;
      seen.pos      = out_digit_position;
      seen.digit    = out_digit_value;
      seen.beat_tog = out_beat_toggle;
      seen.div_tog  = out_div_toggle;
      sb.check_readout(seen);
      rx_count++;
    end
  end

  // receiver stall: random, a quiet window, and one long hold-off
  initial begin : receiver
    bit held;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (!held && rx_count >= HOLD_AT) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_stall <= (rx_count >= QUIET_FROM && rx_count < QUIET_TO) ? 1'b0 :
                   ($urandom_range(99) < IDLE_PCT);
    end
  end

  initial begin : stimulus
    logic [1:0] beat_ab;
    logic [1:0] div_ab;
    int         beat_bias;
    int         div_bias;
    logic       beat_sw;
    logic       div_sw;
    count_t     lo_tab [PHASES];
    count_t     hi_tab [PHASES];
    logic [1:0] turn_down [4];
    logic [1:0] turn_up [4];
    sb = new();
    // defaults, full range, inverted range, single value, both ends, narrow, random
    lo_tab = '{7'd2, 7'd0, 7'd99, 7'd50, 7'd0, 7'd99, 7'd10, 7'd0, 7'd0};
    hi_tab = '{7'd32, 7'd99, 7'd0, 7'd50, 7'd0, 7'd99, 7'd14, 7'd3, 7'd0};
    lo_tab[PHASES-1] = count_t'($urandom_range(99));
    hi_tab[PHASES-1] = count_t'($urandom_range(99));
    turn_down = '{2'b01, 2'b00, 2'b10, 2'b11};
    turn_up   = '{2'b10, 2'b00, 2'b01, 2'b11};

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed scans, fields: beat A B, div A B, beat switch, div switch
    send_scan(6'b11_11_00);
    // opposite arming on the two encoders, both switches pressed together
    send_scan(6'b01_10_11);
    // detents complete: beats down, divisions up; switches held
    send_scan(6'b00_00_11);
    send_scan(6'b10_01_00);
    send_scan(6'b11_11_01);
    // both lines fall in one scan: only the line A edge counts
    send_scan(6'b00_00_00);
    send_scan(6'b01_01_00);
    send_scan(6'b11_11_00);
    send_scan(6'b10_10_00);
    send_scan(6'b11_11_10);
    // beats down through min wraps to max, divisions up
    for (int k = 0; k < 12; k++) begin
      send_scan({turn_down[2'(k)], turn_up[2'(k)], 2'b00});
    end

    // random phases, each under its own limits
    beat_ab   = 2'b11;
    div_ab    = 2'b11;
    beat_bias = 1;
    div_bias  = -1;
    beat_sw   = 1'b0;
    div_sw    = 1'b0;
    for (int p = 0; p < PHASES; p++) begin
      drain();
      set_limits(lo_tab[4'(p)], hi_tab[4'(p)]);
      repeat (SCANS_PER_PHASE) begin
        if ($urandom_range(99) < 3) beat_bias = -beat_bias;
        if ($urandom_range(99) < 3) div_bias = -div_bias;
        beat_ab = next_lines(beat_ab, beat_bias);
        div_ab  = next_lines(div_ab, div_bias);
        if ($urandom_range(99) < 12) beat_sw = ~beat_sw;
        if ($urandom_range(99) < 12) div_sw = ~div_sw;
        send_scan({beat_ab, div_ab, beat_sw, div_sw});
      end
    end

    drain();
    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
